@@ rtl/prap_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for point rotation.
package prap_pkg;

  // Coordinate width, fixed by the request and result fields
  localparam int unsigned COORD_WIDTH = 16;

  // Quarter-wave table: round(sin(d) * 2^14) for d = 0..90
  localparam int unsigned TABLE_FRAC_BITS = 14;
  localparam int unsigned TABLE_ENTRY_W   = 15;
  localparam int unsigned TABLE_IDX_W     = 7;
  localparam int unsigned TABLE_LAST      = 90;

  // Angle reduction: bias the signed angle by a multiple of 360 so that it
  // becomes non-negative, then divide by 360 with a reciprocal multiply.
  localparam int unsigned DEG_QUARTER   = 90;
  localparam int unsigned DEG_HALF      = 180;
  localparam int unsigned DEG_3QUARTER  = 270;
  localparam int unsigned DEG_FULL      = 360;
  localparam int unsigned ANGLE_U_W     = COORD_WIDTH + 1;
  localparam int unsigned ANGLE_BIAS    = DEG_FULL * ((2 ** (COORD_WIDTH - 1)) / DEG_FULL + 1);
  localparam int unsigned RECIP_SHIFT   = 25;
  localparam int unsigned RECIP_MULT    = ((2 ** RECIP_SHIFT) + DEG_FULL - 1) / DEG_FULL;
  localparam int unsigned QUOT_W        = 8;
  localparam int unsigned RESID_W       = 9;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] pivot_x;
    logic signed [COORD_WIDTH-1:0] pivot_y;
    logic signed [COORD_WIDTH-1:0] angle_degrees;
  } prap_req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic signed [COORD_WIDTH-1:0] rotated_z;
    logic                          saturated;
  } prap_rsp_t;

  localparam logic [TABLE_ENTRY_W-1:0] QUARTER_SINE [TABLE_LAST+1] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // Look up the quarter-wave sine; indexes past the last entry clamp to it
  function automatic logic [TABLE_ENTRY_W-1:0] quarter_sine(
    input logic [TABLE_IDX_W-1:0] idx
  );
    logic [TABLE_ENTRY_W-1:0] entry;
    if (idx > TABLE_IDX_W'(TABLE_LAST)) begin
      entry = QUARTER_SINE[TABLE_LAST];
    end else begin
      entry = QUARTER_SINE[idx];
    end
    return entry;
  endfunction

endpackage

@@ rtl/point_rotate_about_pivot.sv @@
// Top level: eight-stage pipeline rotating a point about a pivot in the x-y plane.
//
//  Channel | Handshake                | Payload    | Direction
//  --------+--------------------------+------------+----------
//  request | in_valid_i / in_ready_o  | in_req_i   | in
//  result  | out_valid_o/ out_ready_i | out_rsp_o  | out
//
// One request per clock while the result channel is not stalled.
// Stages: angle quotient, angle residue, quadrant fold, table lookup,
// multiply, sum, truncate and add pivot, saturate.
// Reset clears the stage valid bits only; the data registers are not reset.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up under a stalled output and nothing is dropped or repeated.
module point_rotate_about_pivot
  import prap_pkg::*;
#(
  parameter int unsigned TRIG_FRACTION_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  prap_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output prap_rsp_t out_rsp_o
);

  localparam int unsigned NUM_STAGES = 8;
  localparam int unsigned MAG_W      = TRIG_FRACTION_BITS + 1;
  localparam int unsigned TRIG_W     = MAG_W + 1;
  localparam int unsigned DIFF_W     = COORD_WIDTH + 1;
  localparam int unsigned PROD_W     = DIFF_W + TRIG_W;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned RES_W      = SUM_W - TRIG_FRACTION_BITS;
  localparam int unsigned SHIFT_L    =
    (TRIG_FRACTION_BITS >= TABLE_FRAC_BITS) ? TRIG_FRACTION_BITS - TABLE_FRAC_BITS : 0;
  localparam int unsigned SHIFT_R    =
    (TRIG_FRACTION_BITS < TABLE_FRAC_BITS) ? TABLE_FRAC_BITS - TRIG_FRACTION_BITS : 0;
  localparam int unsigned ROUND_ADD  = (1 << SHIFT_R) >> 1;

  localparam logic [SUM_W-1:0] TRUNC_BIAS =
    {{(SUM_W-TRIG_FRACTION_BITS){1'b0}}, {TRIG_FRACTION_BITS{1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MAX =
    {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN =
    {{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                   neg;
    logic [TABLE_IDX_W-1:0] idx;
  } trig_sel_t;

  // Map an angle in 0..359 to a table index and sign by quadrant symmetry
  function automatic trig_sel_t fold_angle(input logic [RESID_W-1:0] a);
    trig_sel_t          sel;
    logic [RESID_W-1:0] idx_full;
    if (a <= RESID_W'(DEG_QUARTER)) begin
      idx_full = a;
      sel.neg  = 1'b0;
    end else if (a <= RESID_W'(DEG_HALF)) begin
      idx_full = RESID_W'(DEG_HALF) - a;
      sel.neg  = 1'b0;
    end else if (a <= RESID_W'(DEG_3QUARTER)) begin
      idx_full = a - RESID_W'(DEG_HALF);
      sel.neg  = 1'b1;
    end else begin
      idx_full = RESID_W'(DEG_FULL) - a;
      sel.neg  = 1'b1;
    end
    sel.idx = idx_full[TABLE_IDX_W-1:0];
    return sel;
  endfunction

  // Rescale a Q1.14 table entry to the working fraction width
  function automatic logic [MAG_W-1:0] scale_entry(input logic [TABLE_ENTRY_W-1:0] e);
    logic [31:0] w;
    w = ((32'(e) << SHIFT_L) + 32'(ROUND_ADD)) >> SHIFT_R;
    return w[MAG_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stage valid bits and flow control
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] adv;
  logic [NUM_STAGES-1:0] ld;

  // Let a stage load when it is empty or its successor moves
  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  // Advance valid bits with the data
  always_comb begin
    vld_d = vld_q;
    ld    = '0;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
      ld[0]    = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
        ld[k]    = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = adv[0];

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic        [ANGLE_U_W-1:0]   s0_ang_q;
  logic        [QUOT_W-1:0]      s0_quot_q;
  logic signed [DIFF_W-1:0]      s0_dx_q, s0_dy_q;
  logic signed [COORD_WIDTH-1:0] s0_vx_q, s0_vy_q, s0_pz_q;

  logic        [RESID_W-1:0]     s1_sin_ang_q, s1_cos_ang_q;
  logic signed [DIFF_W-1:0]      s1_dx_q, s1_dy_q;
  logic signed [COORD_WIDTH-1:0] s1_vx_q, s1_vy_q, s1_pz_q;

  trig_sel_t                     s2_sin_sel_q, s2_cos_sel_q;
  logic signed [DIFF_W-1:0]      s2_dx_q, s2_dy_q;
  logic signed [COORD_WIDTH-1:0] s2_vx_q, s2_vy_q, s2_pz_q;

  logic signed [TRIG_W-1:0]      s3_sin_q, s3_cos_q;
  logic signed [DIFF_W-1:0]      s3_dx_q, s3_dy_q;
  logic signed [COORD_WIDTH-1:0] s3_vx_q, s3_vy_q, s3_pz_q;

  logic signed [PROD_W-1:0]      s4_xc_q, s4_ys_q, s4_xs_q, s4_yc_q;
  logic signed [COORD_WIDTH-1:0] s4_vx_q, s4_vy_q, s4_pz_q;

  logic signed [SUM_W-1:0]       s5_sx_q, s5_sy_q;
  logic signed [COORD_WIDTH-1:0] s5_vx_q, s5_vy_q, s5_pz_q;

  logic signed [RES_W-1:0]       s6_rx_q, s6_ry_q;
  logic signed [COORD_WIDTH-1:0] s6_pz_q;

  prap_rsp_t                     s7_rsp_q;

  // Stage 0: bias the angle, take its quotient by 360, form pivot offsets
  logic signed [ANGLE_U_W-1:0]   s0_ang_sum;
  logic        [ANGLE_U_W-1:0]   s0_ang_d;
  logic        [2*ANGLE_U_W-1:0] s0_recip_prod;
  logic        [QUOT_W-1:0]      s0_quot_d;
  logic signed [DIFF_W-1:0]      s0_dx_d, s0_dy_d;

  always_comb begin
    s0_ang_sum    = ANGLE_U_W'(in_req_i.angle_degrees) +
                    signed'(ANGLE_U_W'(ANGLE_BIAS));
    s0_ang_d      = unsigned'(s0_ang_sum);
    s0_recip_prod = (2*ANGLE_U_W)'(s0_ang_d) * (2*ANGLE_U_W)'(RECIP_MULT);
    s0_quot_d     = s0_recip_prod[RECIP_SHIFT +: QUOT_W];
    s0_dx_d       = DIFF_W'(in_req_i.point_x) - DIFF_W'(in_req_i.pivot_x);
    s0_dy_d       = DIFF_W'(in_req_i.point_y) - DIFF_W'(in_req_i.pivot_y);
  end

  // Stage 1: residue modulo 360 for sine, and the cosine angle 90 ahead
  logic [ANGLE_U_W-1:0] s1_resid_full;
  logic [RESID_W-1:0]   s1_sin_ang_d, s1_cos_ang_d;

  always_comb begin
    s1_resid_full = s0_ang_q - ANGLE_U_W'(s0_quot_q) * ANGLE_U_W'(DEG_FULL);
    s1_sin_ang_d  = s1_resid_full[RESID_W-1:0];
    if (s1_sin_ang_d >= RESID_W'(DEG_3QUARTER)) begin
      s1_cos_ang_d = s1_sin_ang_d - RESID_W'(DEG_3QUARTER);
    end else begin
      s1_cos_ang_d = s1_sin_ang_d + RESID_W'(DEG_QUARTER);
    end
  end

  // Stage 3: table lookup, rescale, apply quadrant sign
  logic [MAG_W-1:0]         s3_sin_mag, s3_cos_mag;
  logic signed [TRIG_W-1:0] s3_sin_d, s3_cos_d;

  always_comb begin
    s3_sin_mag = scale_entry(quarter_sine(s2_sin_sel_q.idx));
    s3_cos_mag = scale_entry(quarter_sine(s2_cos_sel_q.idx));
    s3_sin_d   = s2_sin_sel_q.neg ? -signed'({1'b0, s3_sin_mag}) : signed'({1'b0, s3_sin_mag});
    s3_cos_d   = s2_cos_sel_q.neg ? -signed'({1'b0, s3_cos_mag}) : signed'({1'b0, s3_cos_mag});
  end

  // Stage 6: truncate toward zero, then add the pivot back
  logic signed [SUM_W-1:0] s6_bx, s6_by;
  logic signed [RES_W-1:0] s6_rx_d, s6_ry_d;

  always_comb begin
    s6_bx   = s5_sx_q + signed'(s5_sx_q[SUM_W-1] ? TRUNC_BIAS : '0);
    s6_by   = s5_sy_q + signed'(s5_sy_q[SUM_W-1] ? TRUNC_BIAS : '0);
    s6_rx_d = signed'(s6_bx[SUM_W-1:TRIG_FRACTION_BITS]) + RES_W'(s5_vx_q);
    s6_ry_d = signed'(s6_by[SUM_W-1:TRIG_FRACTION_BITS]) + RES_W'(s5_vy_q);
  end

  // Stage 7: clip to the coordinate range
  prap_rsp_t s7_rsp_d;
  logic      s7_clip_x, s7_clip_y;

  always_comb begin
    s7_clip_x = 1'b1;
    s7_clip_y = 1'b1;
    priority if (s6_rx_q > SAT_MAX) begin
      s7_rsp_d.rotated_x = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (s6_rx_q < SAT_MIN) begin
      s7_rsp_d.rotated_x = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      s7_rsp_d.rotated_x = s6_rx_q[COORD_WIDTH-1:0];
      s7_clip_x          = 1'b0;
    end
    priority if (s6_ry_q > SAT_MAX) begin
      s7_rsp_d.rotated_y = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (s6_ry_q < SAT_MIN) begin
      s7_rsp_d.rotated_y = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      s7_rsp_d.rotated_y = s6_ry_q[COORD_WIDTH-1:0];
      s7_clip_y          = 1'b0;
    end
    s7_rsp_d.rotated_z = s6_pz_q;
    s7_rsp_d.saturated = s7_clip_x || s7_clip_y;
  end

  // Load each stage when it takes a request from upstream
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_ang_q  <= s0_ang_d;
      s0_quot_q <= s0_quot_d;
      s0_dx_q   <= s0_dx_d;
      s0_dy_q   <= s0_dy_d;
      s0_vx_q   <= in_req_i.pivot_x;
      s0_vy_q   <= in_req_i.pivot_y;
      s0_pz_q   <= in_req_i.point_z;
    end
    if (ld[1]) begin
      s1_sin_ang_q <= s1_sin_ang_d;
      s1_cos_ang_q <= s1_cos_ang_d;
      s1_dx_q      <= s0_dx_q;
      s1_dy_q      <= s0_dy_q;
      s1_vx_q      <= s0_vx_q;
      s1_vy_q      <= s0_vy_q;
      s1_pz_q      <= s0_pz_q;
    end
    if (ld[2]) begin
      s2_sin_sel_q <= fold_angle(s1_sin_ang_q);
      s2_cos_sel_q <= fold_angle(s1_cos_ang_q);
      s2_dx_q      <= s1_dx_q;
      s2_dy_q      <= s1_dy_q;
      s2_vx_q      <= s1_vx_q;
      s2_vy_q      <= s1_vy_q;
      s2_pz_q      <= s1_pz_q;
    end
    if (ld[3]) begin
      s3_sin_q <= s3_sin_d;
      s3_cos_q <= s3_cos_d;
      s3_dx_q  <= s2_dx_q;
      s3_dy_q  <= s2_dy_q;
      s3_vx_q  <= s2_vx_q;
      s3_vy_q  <= s2_vy_q;
      s3_pz_q  <= s2_pz_q;
    end
    if (ld[4]) begin
      s4_xc_q <= PROD_W'(s3_dx_q) * PROD_W'(s3_cos_q);
      s4_ys_q <= PROD_W'(s3_dy_q) * PROD_W'(s3_sin_q);
      s4_xs_q <= PROD_W'(s3_dx_q) * PROD_W'(s3_sin_q);
      s4_yc_q <= PROD_W'(s3_dy_q) * PROD_W'(s3_cos_q);
      s4_vx_q <= s3_vx_q;
      s4_vy_q <= s3_vy_q;
      s4_pz_q <= s3_pz_q;
    end
    if (ld[5]) begin
      s5_sx_q <= SUM_W'(s4_xc_q) - SUM_W'(s4_ys_q);
      s5_sy_q <= SUM_W'(s4_xs_q) + SUM_W'(s4_yc_q);
      s5_vx_q <= s4_vx_q;
      s5_vy_q <= s4_vy_q;
      s5_pz_q <= s4_pz_q;
    end
    if (ld[6]) begin
      s6_rx_q <= s6_rx_d;
      s6_ry_q <= s6_ry_d;
      s6_pz_q <= s5_pz_q;
    end
    if (ld[7]) begin
      s7_rsp_q <= s7_rsp_d;
    end
  end

  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_rsp_o   = s7_rsp_q;

endmodule

@@ rtl/prap_checker.sv @@
// Port-level checks for the point rotation pipeline, bound to the top level.
module prap_checker
  import prap_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input prap_rsp_t out_rsp_o
);

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Hold a result that has not been taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed or dropped while stalled");

  // Drop request ready only under output backpressure
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request ready low without a stalled result");

  // Flag clipping only with a coordinate at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.saturated |->
      out_rsp_o.rotated_x == COORD_MAX || out_rsp_o.rotated_x == COORD_MIN ||
      out_rsp_o.rotated_y == COORD_MAX || out_rsp_o.rotated_y == COORD_MIN)
    else $error("saturated set with both coordinates inside range");

  // Empty pipeline while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && in_ready_o)
    else $error("pipeline not empty during reset");

endmodule

bind point_rotate_about_pivot prap_checker u_prap_checker (.*);

@@ verif/point_rotate_about_pivot_tb.sv @@
// Self-checking testbench for point_rotate_about_pivot: random and directed requests, scored.
module point_rotate_about_pivot_tb;
  import prap_pkg::*;

  localparam int    RANDOM_ITEMS = 1430;
  localparam int    STALL_LIMIT  = 2000;
  localparam int    TAIL_CYCLES  = 24;
  localparam longint TRIG_SCALE  = longint'(1) << TABLE_FRAC_BITS;
  localparam longint COORD_MAX   = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN   = -COORD_MAX - 1;
  localparam longint TURN_DEG    = longint'(DEG_FULL);

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  prap_req_t in_req_i;
  logic      out_valid_o;
  logic      out_ready_i;
  prap_rsp_t out_rsp_o;

  prap_req_t pending_reqs[$];
  prap_rsp_t expected_rsps[$];
  int        total_reqs;
  int        sent_count;
  int        err_count;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;
  logic      in_taken;

  point_rotate_about_pivot uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Sine of a reduced angle in 0..359, scaled by 2^14, by quadrant symmetry
  function automatic longint table_sine(input int a);
    longint v;
    if (a <= DEG_QUARTER) begin
      v = longint'(QUARTER_SINE[a]);
    end else if (a <= DEG_HALF) begin
      v = longint'(QUARTER_SINE[DEG_HALF - a]);
    end else if (a <= DEG_3QUARTER) begin
      v = -longint'(QUARTER_SINE[a - DEG_HALF]);
    end else begin
      v = -longint'(QUARTER_SINE[DEG_FULL - a]);
    end
    return v;
  endfunction

  // Clip to the signed coordinate range and flag any clipping
  function automatic longint clip_coord(input longint v, inout logic clipped);
    longint r;
    r = v;
    if (v > COORD_MAX) begin
      r = COORD_MAX;
      clipped = 1'b1;
    end else if (v < COORD_MIN) begin
      r = COORD_MIN;
      clipped = 1'b1;
    end
    return r;
  endfunction

  // Rotate the point about the pivot; offsets truncate toward zero
  function automatic prap_rsp_t rotate_expected(input prap_req_t r);
    longint    ang, s, c, vx, vy, dx, dy, ox, oy;
    int        a;
    logic      clipped;
    prap_rsp_t rsp;
    ang = longint'($signed(r.angle_degrees));
    a   = int'(((ang % TURN_DEG) + TURN_DEG) % TURN_DEG);
    s   = table_sine(a);
    c   = table_sine((a + DEG_QUARTER) % DEG_FULL);
    vx  = longint'($signed(r.pivot_x));
    vy  = longint'($signed(r.pivot_y));
    dx  = longint'($signed(r.point_x)) - vx;
    dy  = longint'($signed(r.point_y)) - vy;
    clipped = 1'b0;
    ox = clip_coord((dx * c - dy * s) / TRIG_SCALE + vx, clipped);
    oy = clip_coord((dx * s + dy * c) / TRIG_SCALE + vy, clipped);
    rsp.rotated_x = ox[COORD_WIDTH-1:0];
    rsp.rotated_y = oy[COORD_WIDTH-1:0];
    rsp.rotated_z = r.point_z;
    rsp.saturated = clipped;
    return rsp;
  endfunction

  // Queue one request
  task automatic add_req(input int px, input int py, input int pz,
                         input int vx, input int vy, input int ang);
    prap_req_t r;
    r.point_x       = px[COORD_WIDTH-1:0];
    r.point_y       = py[COORD_WIDTH-1:0];
    r.point_z       = pz[COORD_WIDTH-1:0];
    r.pivot_x       = vx[COORD_WIDTH-1:0];
    r.pivot_y       = vy[COORD_WIDTH-1:0];
    r.angle_degrees = ang[COORD_WIDTH-1:0];
    pending_reqs.push_back(r);
  endtask

  // Pick a coordinate: full range, near zero, or at the edges
  function automatic int rand_coord();
    int v;
    case ($urandom_range(5))
      0, 1, 2: v = int'($signed(16'($urandom)));
      3:       v = int'($urandom_range(400)) - 200;
      4:       v = ($urandom_range(1) != 0) ? 32767 - int'($urandom_range(15))
                                            : -32768 + int'($urandom_range(15));
      default: v = ($urandom_range(1) != 0) ? 32767 : -32768;
    endcase
    return v;
  endfunction

  // Pick an angle: full range, one turn, quadrant edges, or turns of zero
  function automatic int rand_angle();
    int v;
    case ($urandom_range(4))
      0, 1:    v = int'($signed(16'($urandom)));
      2:       v = int'($urandom_range(359));
      3:       v = DEG_QUARTER * int'($urandom_range(3)) + int'($urandom_range(2)) - 1
                   + DEG_FULL * (int'($urandom_range(180)) - 90);
      default: v = DEG_FULL * (int'($urandom_range(180)) - 90);
    endcase
    return v;
  endfunction

  // Count and print one mismatch
  task automatic flag_mismatch(input string msg);
    err_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Run the clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Pick the idle rates for the current third of the run
  always_comb begin
    if (sent_count < total_reqs / 3) begin
      send_idle_pct = 14;
      recv_idle_pct = 56;
    end else if (sent_count < (2 * total_reqs) / 3) begin
      send_idle_pct = 56;
      recv_idle_pct = 14;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Drive requests and result ready on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid_i || in_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Score both channels on the rising edge and watch for a hang
  always @(posedge clk_i) begin : score_blk
    prap_rsp_t want;
    prap_rsp_t got;
    logic      any_fire;
    in_taken <= in_valid_i && in_ready_o;
    any_fire = 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_rsps.push_back(rotate_expected(in_req_i));
      sent_count <= sent_count + 1;
      any_fire = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      any_fire = 1'b1;
      got = out_rsp_o;
      if (expected_rsps.size() == 0) begin
        flag_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d sat=%0b",
                                got.rotated_x, got.rotated_y, got.rotated_z,
                                got.saturated));
      end else begin
        want = expected_rsps.pop_front();
        if (got.rotated_x !== want.rotated_x)
          flag_mismatch($sformatf("rotated_x got %0d want %0d",
                                  got.rotated_x, want.rotated_x));
        if (got.rotated_y !== want.rotated_y)
          flag_mismatch($sformatf("rotated_y got %0d want %0d",
                                  got.rotated_y, want.rotated_y));
        if (got.rotated_z !== want.rotated_z)
          flag_mismatch($sformatf("rotated_z got %0d want %0d",
                                  got.rotated_z, want.rotated_z));
        if (got.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated got %0b want %0b",
                                  got.saturated, want.saturated));
      end
    end
    if (any_fire || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Build the stimulus, reset, then wait for the pipeline to drain
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    in_taken    = 1'b0;
    sent_count  = 0;
    err_count   = 0;
    idle_cycles = 0;

    // Zero angle and its multiples return the point unchanged
    add_req(0, 0, 0, 0, 0, 0);
    add_req(32767, -32768, 32767, -32768, 32767, 0);
    add_req(-1234, 567, -1, 89, -90, 360);
    add_req(321, -654, 7, 11, 22, -360);
    add_req(-32768, 32767, 0, 32767, -32768, 720);
    // Quadrant angles and their neighbors
    add_req(100, 0, -32768, 0, 0, 90);
    add_req(100, 50, 5, 10, -20, 180);
    add_req(100, 50, 5, 10, -20, 270);
    add_req(1234, -567, 0, 0, 0, 359);
    add_req(1000, 0, 0, 0, 0, 45);
    add_req(-777, 333, 1, -5, 6, 1);
    add_req(-777, 333, 1, -5, 6, 89);
    add_req(-777, 333, 1, -5, 6, 91);
    add_req(-777, 333, 1, -5, 6, 179);
    add_req(-777, 333, 1, -5, 6, 181);
    add_req(-777, 333, 1, -5, 6, 269);
    add_req(-777, 333, 1, -5, 6, 271);
    // Negative angles and the ends of the angle range
    add_req(100, 50, 5, 10, -20, -90);
    add_req(2000, -3000, 9, -40, 40, 32767);
    add_req(2000, -3000, 9, -40, 40, -32768);
    // Offsets at and beyond the coordinate range, with and without clipping
    add_req(-32768, -32768, -1, 32767, 32767, 180);
    add_req(32767, 32767, 0, -32768, -32768, 45);
    add_req(32767, 0, 0, -32768, 0, 90);
    add_req(32767, 32767, 0, 0, 0, 180);
    add_req(-32768, 0, 0, 0, 0, 180);

    repeat (RANDOM_ITEMS) begin
      add_req(rand_coord(), rand_coord(), int'($signed(16'($urandom))),
              rand_coord(), rand_coord(), rand_angle());
    end
    total_reqs = pending_reqs.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_rsps.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ point_rotate_about_pivot.f @@
rtl/prap_pkg.sv
rtl/point_rotate_about_pivot.sv
rtl/prap_checker.sv
verif/point_rotate_about_pivot_tb.sv
